FILE: rtl/core/mmn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types and constants of the min-max normalizer.
// ----------------------------------------------------------------------------
package mmn_pkg;

	localparam int DATA_W     = 16;
	localparam int REG_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int K_W        = 32;

	localparam logic [0:0] REG_LOW_BOUND  = 1'b0;
	localparam logic [0:0] REG_HIGH_BOUND = 1'b1;

	localparam logic signed [DATA_W-1:0] LOW_BOUND_RST  = 16'sd0;
	localparam logic signed [DATA_W-1:0] HIGH_BOUND_RST = 16'sd256;
	localparam logic signed [DATA_W-1:0] S16_MAX        = 16'sh7FFF;
	localparam logic signed [DATA_W-1:0] S16_MIN        = 16'sh8000;
	localparam logic [K_W-1:0]           K_POS_SAT      = 32'h7FFF_FFFF;
	localparam logic [K_W-1:0]           K_NEG_SAT      = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PREP,
		ST_DIVIDE,
		ST_SCALE,
		ST_EMIT,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic load;
		logic div_init;
		logic div_step;
		logic latch_k;
		logic issue;
		logic issue_last;
		logic clear_vec;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic all_eq;
		logic advance;
		logic pipe_empty;
	} status_t;

endpackage

FILE: rtl/core/mmn_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_in_if
// Sample channel: one signed Q8.8 sample and an end-of-vector flag per word.
// ----------------------------------------------------------------------------
interface mmn_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               last;

	modport source(output valid, output sample, output last, input ready);
	modport sink(input valid, input sample, input last, output ready);
endinterface

FILE: rtl/core/mmn_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_out_if
// Result channel: one normalized Q8.8 element and an end-of-vector flag.
// ----------------------------------------------------------------------------
interface mmn_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] scaled;
	logic               final_res;

	modport source(output valid, output scaled, output final_res, input ready);
	modport sink(input valid, input scaled, input final_res, output ready);
endinterface

FILE: rtl/core/mmn_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_regs
// APB register file holding the target interval bounds.
// ----------------------------------------------------------------------------
module mmn_regs (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [mmn_pkg::REG_ADDR_W-1:0]          paddr,
	input  logic [mmn_pkg::APB_DATA_W-1:0]          pwdata,
	output logic [mmn_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                    pready,
	output logic signed [mmn_pkg::DATA_W-1:0]       low_bound,
	output logic signed [mmn_pkg::DATA_W-1:0]       high_bound
);
	import mmn_pkg::*;

	logic signed [DATA_W-1:0] low_q;
	logic signed [DATA_W-1:0] high_q;
	logic                     wr_en;
	logic [0:0]               reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_BOUND_RST;
			high_q <= HIGH_BOUND_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LOW_BOUND:  low_q  <= pwdata[DATA_W-1:0];
				REG_HIGH_BOUND: high_q <= pwdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LOW_BOUND:  prdata = APB_DATA_W'(low_q);
			REG_HIGH_BOUND: prdata = APB_DATA_W'(high_q);
			default:        prdata = '0;
		endcase
	end

	assign low_bound  = low_q;
	assign high_bound = high_q;

endmodule

FILE: rtl/core/mmn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_ctrl
// Sequencer: load, divide unless all samples match, then stream stored samples.
// ----------------------------------------------------------------------------
module mmn_ctrl #(
	parameter int DEPTH           = 64,
	parameter int SCALE_FRAC_BITS = 16,
	localparam int AW             = $clog2(DEPTH),
	localparam int CW             = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mmn_pkg::status_t  st,
	input  logic [CW-1:0]     count,
	output mmn_pkg::cmd_t     cmd,
	output logic [AW-1:0]     rd_addr
);
	import mmn_pkg::*;

	localparam int QW = DATA_W + SCALE_FRAC_BITS;
	localparam int SW = $clog2(QW);

	state_t        state_q, state_d;
	logic [SW-1:0] step_q;
	logic [AW-1:0] addr_q;
	logic          at_last;

	assign at_last = CW'(addr_q) == CW'(count - CW'(1));
	assign rd_addr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + SW'(1);
			if (cmd.div_init)
				addr_q <= '0;
			else if (cmd.issue)
				addr_q <= addr_q + AW'(1);
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && st.close)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.div_init = 1'b1;
				state_d      = st.all_eq ? ST_EMIT : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (step_q == SW'(QW - 1))
					state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.latch_k = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (st.advance) begin
					cmd.issue      = 1'b1;
					cmd.issue_last = at_last;
					if (at_last)
						state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (st.pipe_empty) begin
					cmd.clear_vec = 1'b1;
					state_d       = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

endmodule

FILE: rtl/core/mmn_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_dp
// Sample store, min/max tracking, radix-2 divider and the scaling pipeline.
// ----------------------------------------------------------------------------
module mmn_dp #(
	parameter int DEPTH           = 64,
	parameter int SCALE_FRAC_BITS = 16,
	localparam int AW             = $clog2(DEPTH),
	localparam int CW             = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mmn_pkg::cmd_t                      cmd,
	output mmn_pkg::status_t                   st,
	output logic [CW-1:0]                      count,
	input  logic [AW-1:0]                      rd_addr,
	input  logic signed [mmn_pkg::DATA_W-1:0]  low_bound,
	input  logic signed [mmn_pkg::DATA_W-1:0]  high_bound,
	input  logic signed [mmn_pkg::DATA_W-1:0]  sample,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [mmn_pkg::DATA_W-1:0]  scaled,
	output logic                               final_res
);
	import mmn_pkg::*;

	localparam int F  = SCALE_FRAC_BITS;
	localparam int QW = DATA_W + F;
	localparam int DW = DATA_W + 1;
	localparam int PW = DW + K_W;

	logic [DATA_W-1:0]        mem [DEPTH];
	logic [CW-1:0]            count_q;
	logic signed [DATA_W-1:0] max_q, min_q;

	// divider
	logic signed [DW-1:0]     span;
	logic [DW-1:0]            mag;
	logic [DATA_W-1:0]        den;
	logic                     neg_q;
	logic [QW-1:0]            quo_q;
	logic [DATA_W-1:0]        rem_q;
	logic [DW-1:0]            trial;
	logic                     fits;
	logic [63:0]              quo_ext;
	logic [K_W-1:0]           k_sat;
	logic signed [K_W-1:0]    k_q;

	// emission pipeline
	logic                     advance;
	logic                     v_s1, l_s1, v_s2, l_s2;
	logic signed [DATA_W-1:0] x_s1;
	logic signed [DW-1:0]     diff;
	logic signed [PW-1:0]     prod;
	logic signed [PW-1:0]     p_s2;
	logic signed [PW-1:0]     shr;
	logic signed [PW-1:0]     sum;
	logic signed [DATA_W-1:0] res;
	logic                     out_valid_q, final_q;
	logic signed [DATA_W-1:0] scaled_q;

	assign st.close      = last | (count_q == CW'(DEPTH - 1));
	assign st.all_eq     = max_q == min_q;
	assign advance       = !out_valid_q || out_ready;
	assign st.advance    = advance;
	assign st.pipe_empty = !v_s1 && !v_s2 && !out_valid_q;
	assign count         = count_q;

	always_ff @(posedge clk) begin
		if (cmd.load)
			mem[count_q[AW-1:0]] <= sample;
		if (cmd.issue)
			x_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= S16_MIN;
			min_q   <= S16_MAX;
		end else if (cmd.clear_vec) begin
			count_q <= '0;
			max_q   <= S16_MIN;
			min_q   <= S16_MAX;
		end else if (cmd.load) begin
			count_q <= count_q + CW'(1);
			if (sample > max_q)
				max_q <= sample;
			if (sample < min_q)
				min_q <= sample;
		end
	end

	assign span  = DW'(high_bound) - DW'(low_bound);
	assign mag   = span[DW-1] ? DW'(-span) : span;
	assign den   = DATA_W'(DW'(max_q) - DW'(min_q));
	assign trial = {rem_q, quo_q[QW-1]};
	assign fits  = trial >= DW'(den);

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= span[DW-1];
			quo_q <= {mag[DATA_W-1:0], {F{1'b0}}};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? DATA_W'(trial - DW'(den)) : trial[DATA_W-1:0];
		end
	end

	assign quo_ext = 64'(quo_q);

	always_comb begin
		if (!neg_q)
			k_sat = (quo_ext > 64'(K_POS_SAT)) ? K_POS_SAT : quo_ext[K_W-1:0];
		else
			k_sat = (quo_ext > 64'(K_NEG_SAT)) ? K_NEG_SAT
				: K_W'(~quo_ext[K_W-1:0] + K_W'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_k)
			k_q <= k_sat;
	end

	assign diff = DW'(x_s1) - DW'(max_q);
	assign prod = diff * k_q;
	assign shr  = p_s2 >>> F;
	assign sum  = shr + PW'(high_bound);

	always_comb begin
		if (st.all_eq)
			res = low_bound;
		else if (sum > PW'(S16_MAX))
			res = S16_MAX;
		else if (sum < PW'(S16_MIN))
			res = S16_MIN;
		else
			res = sum[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			l_s1     <= cmd.issue_last;
			l_s2     <= l_s1;
			p_s2     <= prod;
			final_q  <= l_s2;
			scaled_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign scaled    = scaled_q;
	assign final_res = final_q;

endmodule

FILE: rtl/core/min_max_normalizer_unit.sv
`timescale 1ns / 1ps
// Samples load at one word per cycle in the load state. The closing sample is
// followed by a prepare step, the one-bit-per-cycle divider (skipped when all
// samples are equal), a scale step and the emission pipeline; results then stream
// at one word per cycle while result_ch.ready is high. No vector overlaps another.
// Reset (arst_n, async): control cleared, low_bound = 0, high_bound = 256;
// sample store contents are undefined and never read before being written.
// ----------------------------------------------------------------------------
// min_max_normalizer_unit
// Min-max normalizer of signed Q8.8 vectors into a configurable interval.
// ----------------------------------------------------------------------------
module min_max_normalizer_unit #(
	parameter int DEPTH           = 64,
	parameter int SCALE_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mmn_pkg::REG_ADDR_W-1:0]     paddr,
	input  logic [mmn_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [mmn_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	mmn_in_if.sink                             sample_ch,
	mmn_out_if.source                          result_ch
);
	import mmn_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [DATA_W-1:0] low_bound, high_bound;
	cmd_t                     cmd;
	status_t                  st;
	logic [CW-1:0]            count;
	logic [AW-1:0]            rd_addr;

	mmn_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.low_bound (low_bound),
		.high_bound(high_bound)
	);

	mmn_ctrl #(
		.DEPTH          (DEPTH),
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(sample_ch.valid),
		.in_ready(sample_ch.ready),
		.st      (st),
		.count   (count),
		.cmd     (cmd),
		.rd_addr (rd_addr)
	);

	mmn_dp #(
		.DEPTH          (DEPTH),
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.count     (count),
		.rd_addr   (rd_addr),
		.low_bound (low_bound),
		.high_bound(high_bound),
		.sample    (sample_ch.sample),
		.last      (sample_ch.last),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.scaled    (result_ch.scaled),
		.final_res (result_ch.final_res)
	);

endmodule

FILE: rtl/core/mmn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmn_checker
// Port-level checks of the min-max normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module mmn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] scaled,
	input logic        final_res,
	input logic        pready
);

	// no loading while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("sample accepted while results pending");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> !in_ready)
		else $error("loading continued after last sample");

	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && final_res) |=> !out_valid)
		else $error("result after final word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(scaled) && $stable(final_res)))
		else $error("stalled result word changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind min_max_normalizer_unit mmn_checker u_mmn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (sample_ch.valid),
	.in_ready (sample_ch.ready),
	.in_last  (sample_ch.last),
	.out_valid(result_ch.valid),
	.out_ready(result_ch.ready),
	.scaled   (result_ch.scaled),
	.final_res(result_ch.final_res),
	.pready   (pready)
);
